// ===== hdl/ots_pkg.sv =====
// ----------------------------------------------------------------------------
// ots_pkg
// Shared constants and types for the oscillator trim search block.
// ----------------------------------------------------------------------------
package ots_pkg;

	localparam int COUNT_BITS_DEF    = 20;
	localparam int TRIM_BITS_DEF     = 8;
	localparam int IDEAL_COUNT_RESET = 895;

	localparam logic OP_BEGIN   = 1'b0;
	localparam logic OP_MEASURE = 1'b1;

	typedef struct packed {
		logic was_above;
		logic was_below;
		logic search_done;
	} flags_t;

	typedef struct packed {
		logic finished;
		logic apply_trim;
	} res_t;

endpackage

// ===== hdl/ots_step.sv =====
// ----------------------------------------------------------------------------
// ots_step
// One search step: next trim, history and result flags for one item.
// ----------------------------------------------------------------------------
module ots_step #(
	parameter int COUNT_BITS = ots_pkg::COUNT_BITS_DEF,
	parameter int TRIM_BITS  = ots_pkg::TRIM_BITS_DEF
) (
	input  logic                  opcode,
	input  logic [COUNT_BITS-1:0] measured_count,
	input  logic [TRIM_BITS-1:0]  start_trim,
	input  logic [COUNT_BITS-1:0] ideal_count,
	input  logic [TRIM_BITS-1:0]  trim_now,
	input  logic [TRIM_BITS-1:0]  trim_before,
	input  logic [COUNT_BITS-1:0] count_before,
	input  ots_pkg::flags_t       flags,
	output logic [TRIM_BITS-1:0]  trim_now_nxt,
	output logic [TRIM_BITS-1:0]  trim_before_nxt,
	output logic [COUNT_BITS-1:0] count_before_nxt,
	output ots_pkg::flags_t       flags_nxt,
	output ots_pkg::res_t         res
);
	import ots_pkg::*;

	localparam logic [TRIM_BITS-1:0]  TRIM_MAX = '1;
	localparam logic [COUNT_BITS-1:0] ONE      = COUNT_BITS'(1);

	logic [COUNT_BITS-1:0] d_lo;
	logic [COUNT_BITS-1:0] d_hi;
	logic [COUNT_BITS-1:0] d_prev;
	logic                  is_low;
	logic                  is_high;

	assign is_low  = measured_count < ideal_count;
	assign is_high = measured_count > ideal_count;
	assign d_lo    = ideal_count - measured_count;
	assign d_hi    = measured_count - ideal_count;
	assign d_prev  = (count_before > ideal_count) ? (count_before - ideal_count)
	                                              : (ideal_count - count_before);

	always_comb begin
		trim_now_nxt     = trim_now;
		trim_before_nxt  = trim_before;
		count_before_nxt = count_before;
		flags_nxt        = flags;
		res.apply_trim   = 1'b0;
		if (opcode == OP_BEGIN) begin
			trim_now_nxt     = start_trim;
			trim_before_nxt  = '0;
			count_before_nxt = '0;
			flags_nxt        = '0;
		end else if (!flags.search_done) begin
			priority if (is_low) begin
				res.apply_trim = 1'b1;
				if (flags.was_above) begin
					if (d_lo > d_prev)
						trim_now_nxt = trim_before;
					flags_nxt.search_done = 1'b1;
				end else if (d_lo == ONE) begin
					flags_nxt.search_done = 1'b1;
				end else begin
					trim_before_nxt     = trim_now;
					trim_now_nxt        = (trim_now < TRIM_MAX) ? trim_now + 1'b1 : trim_now;
					flags_nxt.was_below = 1'b1;
					count_before_nxt    = measured_count;
				end
			end else if (is_high) begin
				res.apply_trim = 1'b1;
				if (flags.was_below) begin
					if (d_hi > d_prev)
						trim_now_nxt = trim_before;
					flags_nxt.search_done = 1'b1;
				end else if (d_hi == ONE) begin
					flags_nxt.search_done = 1'b1;
				end else begin
					trim_before_nxt     = trim_now;
					trim_now_nxt        = (trim_now != '0) ? trim_now - 1'b1 : trim_now;
					flags_nxt.was_above = 1'b1;
					count_before_nxt    = measured_count;
				end
			end else begin
				flags_nxt.search_done = 1'b1;
			end
		end
		res.finished = flags_nxt.search_done;
	end

endmodule

// ===== hdl/oscillator_trim_search.sv =====
// ----------------------------------------------------------------------------
// oscillator_trim_search
// Steps an oscillator trim toward a target window count, one result per item.
// ----------------------------------------------------------------------------
// channel | direction | signals                    | contents
// s_      | in        | s_tvalid s_tready s_tdata  | count, start trim; tuser opcode
// m_      | out       | m_tvalid m_tready m_tdata  | trim value; tuser apply, finished
// cfg_    | in        | cfg_valid cfg_ready cfg_data | ideal count
//
// Input beat to output beat passes the input register, step logic and the
// result register. One item per cycle sustained while the output is not stalled.
// Reset: search idle (finished), ideal count 895; cfg_ready is always high.
// A stalled output holds the result; the input register still takes a beat,
// then s_tready drops until the output moves.
// ----------------------------------------------------------------------------
module oscillator_trim_search #(
	parameter int COUNT_BITS = ots_pkg::COUNT_BITS_DEF,
	parameter int TRIM_BITS  = ots_pkg::TRIM_BITS_DEF,
	localparam int IN_W      = ((COUNT_BITS + TRIM_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((TRIM_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // measured_count, start_trim, zero pad
	input  logic                  s_tuser,   // opcode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // trim_value, zero pad
	output logic [1:0]            m_tuser,   // apply_trim, finished
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_BITS-1:0] cfg_data
);
	import ots_pkg::*;

	localparam logic [COUNT_BITS-1:0] IDEAL_RST = COUNT_BITS'(IDEAL_COUNT_RESET);

	logic                  valid_s1;
	logic                  op_s1;
	logic [COUNT_BITS-1:0] cnt_s1;
	logic [TRIM_BITS-1:0]  start_s1;
	logic                  advance;

	logic [COUNT_BITS-1:0] ideal_q;
	logic [TRIM_BITS-1:0]  trim_now_q;
	logic [TRIM_BITS-1:0]  trim_before_q;
	logic [COUNT_BITS-1:0] count_before_q;
	flags_t                flags_q;

	logic [TRIM_BITS-1:0]  trim_now_nxt;
	logic [TRIM_BITS-1:0]  trim_before_nxt;
	logic [COUNT_BITS-1:0] count_before_nxt;
	flags_t                flags_nxt;
	res_t                  res;

	logic                  valid_s2;
	logic [TRIM_BITS-1:0]  trim_s2;
	res_t                  res_s2;

	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_q <= IDEAL_RST;
		end else if (cfg_valid) begin
			ideal_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= s_tuser;
			cnt_s1   <= s_tdata[COUNT_BITS-1:0];
			start_s1 <= s_tdata[COUNT_BITS+TRIM_BITS-1:COUNT_BITS];
		end
	end

	ots_step #(
		.COUNT_BITS(COUNT_BITS),
		.TRIM_BITS (TRIM_BITS)
	) u_step (
		.opcode          (op_s1),
		.measured_count  (cnt_s1),
		.start_trim      (start_s1),
		.ideal_count     (ideal_q),
		.trim_now        (trim_now_q),
		.trim_before     (trim_before_q),
		.count_before    (count_before_q),
		.flags           (flags_q),
		.trim_now_nxt    (trim_now_nxt),
		.trim_before_nxt (trim_before_nxt),
		.count_before_nxt(count_before_nxt),
		.flags_nxt       (flags_nxt),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_now_q     <= '0;
			trim_before_q  <= '0;
			count_before_q <= '0;
			flags_q        <= '{was_above: 1'b0, was_below: 1'b0, search_done: 1'b1};
			valid_s2       <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				trim_now_q     <= trim_now_nxt;
				trim_before_q  <= trim_before_nxt;
				count_before_q <= count_before_nxt;
				flags_q        <= flags_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			trim_s2 <= trim_now_nxt;
			res_s2  <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'(trim_s2);
	assign m_tuser  = {res_s2.finished, res_s2.apply_trim};

endmodule

// ===== hdl/ots_checker.sv =====
// ----------------------------------------------------------------------------
// ots_checker
// Port-level checks for the oscillator trim search, bound to the top level.
// ----------------------------------------------------------------------------
module ots_checker #(
	parameter int COUNT_BITS = ots_pkg::COUNT_BITS_DEF,
	parameter int TRIM_BITS  = ots_pkg::TRIM_BITS_DEF,
	localparam int IN_W      = ((COUNT_BITS + TRIM_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((TRIM_BITS + 7) / 8) * 8
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_W-1:0]       s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_W-1:0]      m_tdata,
	input logic [1:0]            m_tuser,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [COUNT_BITS-1:0] cfg_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// a fresh result follows an input beat through the input and result registers
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result beat without matching input beat");

	// input backpressure only when the output is stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	// config channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	// offered payloads are fully known
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid || cfg_valid) |-> !$isunknown({s_tuser, s_tdata, cfg_data}))
		else $error("unknown payload on an offered beat");

endmodule

bind oscillator_trim_search ots_checker #(
	.COUNT_BITS(COUNT_BITS),
	.TRIM_BITS (TRIM_BITS)
) u_ots_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_data (cfg_data)
);

// ===== dv/oscillator_trim_search_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oscillator_trim_search_tb
// Self-checking bench for the trim search. Every input beat updates a
// software copy of the search state and queues the expected trim, apply flag
// and finished flag. Output beats are compared against that queue in order.
// Directed steps hit saturation, crossing, ties, exact and off-by-one hits.
// Random phases then run oscillator-like searches under several ideal counts,
// with random gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module oscillator_trim_search_tb;

	localparam int COUNT_W = ots_pkg::COUNT_BITS_DEF;
	localparam int TRIM_W  = ots_pkg::TRIM_BITS_DEF;
	localparam int IN_W    = ((COUNT_W + TRIM_W + 7) / 8) * 8;
	localparam int OUT_W   = ((TRIM_W + 7) / 8) * 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TRIM_W-1:0]  TRIM_MAX  = '1;
	localparam int                 PHASES    = 8;
	localparam int                 PHASE_LEN = 95;

	typedef struct packed {
		logic [TRIM_W-1:0] trim;
		logic              apply;
		logic              done;
	} trim_result_t;

	class trim_scoreboard;
		logic [COUNT_W-1:0] ideal;
		logic [TRIM_W-1:0]  trim_now;
		logic [TRIM_W-1:0]  trim_before;
		logic [COUNT_W-1:0] count_before;
		logic               was_above;
		logic               was_below;
		logic               search_done;
		trim_result_t       expected_q[$];
		int                 errors;
		int                 checked;
		int                 begins;
		int                 settled;

		function new();
			ideal        = COUNT_W'(ots_pkg::IDEAL_COUNT_RESET);
			trim_now     = '0;
			trim_before  = '0;
			count_before = '0;
			was_above    = 1'b0;
			was_below    = 1'b0;
			search_done  = 1'b1;
			errors       = 0;
			checked      = 0;
			begins       = 0;
			settled      = 0;
		endfunction

		function logic [COUNT_W-1:0] distance(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void note_beat(logic op, logic [COUNT_W-1:0] cnt, logic [TRIM_W-1:0] start);
			logic               apply;
			logic [COUNT_W-1:0] miss;
			trim_result_t       res;
			apply = 1'b0;
			if (op == ots_pkg::OP_BEGIN) begin
				trim_now     = start;
				trim_before  = '0;
				count_before = '0;
				was_above    = 1'b0;
				was_below    = 1'b0;
				search_done  = 1'b0;
				begins++;
			end else if (!search_done) begin
				if (cnt < ideal) begin
					miss = ideal - cnt;
					if (was_above) begin
						if (miss > distance(count_before, ideal))
							trim_now = trim_before;
						search_done = 1'b1;
					end else if (miss == COUNT_W'(1)) begin
						search_done = 1'b1;
					end else begin
						trim_before = trim_now;
						if (trim_now != TRIM_MAX)
							trim_now = trim_now + 1'b1;
						was_below    = 1'b1;
						count_before = cnt;
					end
					apply = 1'b1;
				end else if (cnt > ideal) begin
					miss = cnt - ideal;
					if (was_below) begin
						if (miss > distance(ideal, count_before))
							trim_now = trim_before;
						search_done = 1'b1;
					end else if (miss == COUNT_W'(1)) begin
						search_done = 1'b1;
					end else begin
						trim_before = trim_now;
						if (trim_now != '0)
							trim_now = trim_now - 1'b1;
						was_above    = 1'b1;
						count_before = cnt;
					end
					apply = 1'b1;
				end else begin
					search_done = 1'b1;
				end
				if (search_done)
					settled++;
			end
			res.trim  = trim_now;
			res.apply = apply;
			res.done  = search_done;
			expected_q.push_back(res);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 30)
				$display("%0t ns: result %0d: %s", $time, checked, what);
		endtask

		task check_beat(trim_result_t got);
			trim_result_t want;
			if (expected_q.size() == 0) begin
				report("output beat with nothing expected");
				return;
			end
			want = expected_q.pop_front();
			if (got.trim !== want.trim)
				report($sformatf("trim_value got %0d want %0d", got.trim, want.trim));
			if (got.apply !== want.apply)
				report($sformatf("apply_trim got %b want %b", got.apply, want.apply));
			if (got.done !== want.done)
				report($sformatf("finished got %b want %b", got.done, want.done));
			checked++;
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;   // measured_count, start_trim, zero pad
	logic                s_tuser;   // opcode
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;   // trim_value, zero pad
	logic [1:0]          m_tuser;   // apply_trim, finished
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data;

	trim_scoreboard      sb;
	ots_pkg::res_t       out_flags;
	trim_result_t        seen;
	logic                tx_calm;
	logic                rx_calm;
	logic                hold_request;
	int                  hold_left;
	int                  stall_left;
	int                  cfg_writes;

	assign out_flags = m_tuser;

	oscillator_trim_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.trim  = m_tdata[TRIM_W-1:0];
				seen.apply = out_flags.apply_trim;
				seen.done  = out_flags.finished;
				sb.check_beat(seen);
			end
			if (s_tvalid && s_tready)
				sb.note_beat(s_tuser, s_tdata[COUNT_W-1:0], s_tdata[COUNT_W +: TRIM_W]);
		end
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin
		m_tready   = 1'b0;
		hold_left  = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_calm) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
				                                          : $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("oscillator_trim_search_tb: FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_item(logic op, logic [COUNT_W-1:0] cnt, logic [TRIM_W-1:0] start);
		int gap;
		int r;
		r = $urandom_range(0, 9);
		if (tx_calm || r < 6)
			gap = 0;
		else if (r < 9)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_W'({start, cnt});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_ideal(logic [COUNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.ideal = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// counts from a linear oscillator: count = ideal + (trim - t0) * slope + noise
	task automatic run_search_phase(int quota);
		int                 sent;
		int                 m;
		int                 r;
		logic               op;
		logic [TRIM_W-1:0]  start;
		longint             t0;
		longint             slope;
		longint             spread;
		longint             raw;
		sent = 0;
		while (sent < quota) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				op = $urandom_range(0, 1);
				if (op == ots_pkg::OP_BEGIN || !sb.search_done)
					sent++;
				send_item(op, COUNT_W'($urandom_range(0, COUNT_MAX)),
				          TRIM_W'($urandom_range(0, TRIM_MAX)));
				continue;
			end
			r = $urandom_range(0, 99);
			start = (r < 15) ? '0 : (r < 30) ? TRIM_MAX : TRIM_W'($urandom_range(0, TRIM_MAX));
			if (!(r >= 90 && !sb.search_done)) begin
				send_item(ots_pkg::OP_BEGIN, COUNT_W'($urandom_range(0, COUNT_MAX)), start);
				sent++;
			end
			if ($urandom_range(0, 99) < 15)
				t0 = (sb.trim_now > TRIM_MAX / 2) ? longint'(TRIM_MAX) + 40 : -40;
			else
				t0 = longint'(sb.trim_now) + longint'($urandom_range(0, 50)) - 25;
			r = $urandom_range(0, 3);
			if (r == 0) begin
				slope  = 1;
				spread = 0;
			end else begin
				slope  = (r == 1) ? $urandom_range(2, 40) : $urandom_range(200, 5000);
				spread = slope / 3;
			end
			m = 0;
			while (m < 40 && !sb.search_done) begin
				raw = longint'(sb.ideal) + (longint'(sb.trim_now) - t0) * slope
				      + longint'($urandom_range(0, 2 * spread)) - spread;
				if (raw < 0)
					raw = 0;
				if (raw > longint'(COUNT_MAX))
					raw = COUNT_MAX;
				send_item(ots_pkg::OP_MEASURE, COUNT_W'(raw), TRIM_W'($urandom_range(0, TRIM_MAX)));
				m++;
				sent++;
			end
			if ($urandom_range(0, 4) == 0)
				send_item(ots_pkg::OP_MEASURE, COUNT_W'($urandom_range(0, COUNT_MAX)), '0);
		end
	endtask

	initial begin
		logic [COUNT_W-1:0] ideals [PHASES];
		sb           = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = ots_pkg::OP_BEGIN;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		tx_calm      = 1'b0;
		rx_calm      = 1'b0;
		hold_request = 1'b0;
		cfg_writes   = 0;
		ideals[0] = '0;
		ideals[1] = COUNT_MAX;
		ideals[2] = COUNT_W'(ots_pkg::IDEAL_COUNT_RESET);
		ideals[3] = COUNT_W'(1);
		ideals[4] = COUNT_W'($urandom_range(2, COUNT_MAX - 2));
		ideals[5] = COUNT_W'(20'h80000);
		ideals[6] = COUNT_W'($urandom_range(2, 4000));
		ideals[7] = COUNT_MAX - 1'b1;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset ideal count of 895
		send_item(ots_pkg::OP_MEASURE, 20'd100, 8'd0);         // idle, ignored
		send_item(ots_pkg::OP_BEGIN, 20'd0, TRIM_MAX);
		send_item(ots_pkg::OP_MEASURE, 20'd0, 8'd0);           // low, trim pinned at max
		send_item(ots_pkg::OP_MEASURE, COUNT_MAX, 8'd0);       // crossing, far side worse
		send_item(ots_pkg::OP_MEASURE, 20'd895, 8'd0);         // after finish, ignored
		send_item(ots_pkg::OP_BEGIN, COUNT_MAX, 8'd0);
		send_item(ots_pkg::OP_MEASURE, 20'd2000, TRIM_MAX);    // high, trim pinned at zero
		send_item(ots_pkg::OP_MEASURE, 20'd895, 8'd0);         // exact hit
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd128);
		send_item(ots_pkg::OP_MEASURE, 20'd894, 8'd0);         // one below
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd128);
		send_item(ots_pkg::OP_MEASURE, 20'd896, 8'd0);         // one above
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd100);
		send_item(ots_pkg::OP_MEASURE, 20'd800, 8'd0);
		send_item(ots_pkg::OP_MEASURE, 20'd990, 8'd0);         // tie keeps current
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd100);
		send_item(ots_pkg::OP_MEASURE, 20'd1000, 8'd0);
		send_item(ots_pkg::OP_MEASURE, 20'd700, 8'd0);         // revert to previous
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd50);
		send_item(ots_pkg::OP_MEASURE, 20'd895, 8'd0);
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd7);
		send_item(ots_pkg::OP_MEASURE, 20'd893, 8'd0);
		send_item(ots_pkg::OP_MEASURE, 20'd897, 8'd0);
		send_item(ots_pkg::OP_BEGIN, 20'd0, 8'd1);
		send_item(ots_pkg::OP_MEASURE, 20'd3000, 8'd0);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_ideal(ideals[p]);
			tx_calm = (p == 2 || p == 4);
			rx_calm = (p == 2);
			if (p == 4)
				hold_request = 1'b1;
			run_search_phase(PHASE_LEN);
			wait_idle();
		end

		repeat (10) @(negedge clk);
		$display("covered: %0d results checked, %0d searches begun, %0d settled by a measurement",
		         sb.checked, sb.begins, sb.settled);
		$display("covered: %0d ideal-count writes including both extremes, one long output hold-off",
		         cfg_writes);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("oscillator_trim_search_tb: PASS");
		else
			$display("oscillator_trim_search_tb: FAIL");
		$finish;
	end

endmodule

// ===== oscillator_trim_search.f =====
hdl/ots_pkg.sv
hdl/ots_step.sv
hdl/oscillator_trim_search.sv
hdl/ots_checker.sv
dv/oscillator_trim_search_tb.sv
